// File: rtl/core/gb3_pkg.sv
package gb3_pkg;

    // Pixel and field widths
    localparam int CH_W      = 8;
    localparam int ROW_W     = 16;
    localparam int COL_W     = 11;
    localparam int FW_W      = 12;
    localparam int FH_W      = 16;
    localparam int WEIGHT_W  = 16;

    // Kernel arithmetic: weights are unsigned fixed point with this many fraction bits
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int SUM_W     = CH_W + 2;
    localparam int PROD_W    = SUM_W + WEIGHT_W;
    localparam int ACC_W     = PROD_W + 2;

    // Default line buffer depth (widest supported row)
    localparam int MAX_WIDTH_DEF = 2048;

    // Channel positions inside a pixel word
    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_WEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_WEIGHT = 3'd4;

    localparam logic [FW_W-1:0]     FRAME_WIDTH_RST   = 12'd640;
    localparam logic [FH_W-1:0]     FRAME_HEIGHT_RST  = 16'd480;
    localparam logic [WEIGHT_W-1:0] CORNER_WEIGHT_RST = 16'd6209;
    localparam logic [WEIGHT_W-1:0] EDGE_WEIGHT_RST   = 16'd7754;
    localparam logic [WEIGHT_W-1:0] CENTRE_WEIGHT_RST = 16'd9684;

    // One RGB888 pixel: [2] red, [1] green, [0] blue
    typedef logic [2:0][CH_W-1:0] rgb_t;

    // Line buffer entry: the pixel two rows up and the pixel one row up
    typedef struct packed {
        rgb_t two_above;
        rgb_t above;
    } line_pair_t;

    // Up to three results caused by one pixel, handed to the output sequencer
    typedef struct packed {
        rgb_t              first_px;  // pixel (r-1, c-1), blurred or passed
        rgb_t              mid_px;    // pixel (r-1, c), last column only
        rgb_t              cur_px;    // pixel (r, c), last row only
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } grp_t;

endpackage

// File: rtl/core/gb3_if.sv
// Pixel word into the filter
interface gb3_video_if import gb3_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    output ready);
endinterface

// Filtered pixel word with its position
interface gb3_result_if import gb3_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             last_of_run;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_row, output out_col, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_row, input out_col, input last_of_run,
                    output ready);
endinterface

// File: rtl/core/gb3_line_buf.sv
module gb3_line_buf import gb3_pkg::*; #(
    parameter int DEPTH = MAX_WIDTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output line_pair_t    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  line_pair_t    wr_data
);

    line_pair_t store_mem [DEPTH];
    line_pair_t rd_data_reg;

    // One write and one registered read per cycle; read data holds between reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/gb3_kernel.sv
module gb3_kernel import gb3_pkg::*; (
    input  logic                clk,
    input  logic                load,
    input  rgb_t [3:0]          diag,
    input  rgb_t [3:0]          orth,
    input  rgb_t                centre,
    input  logic [WEIGHT_W-1:0] corner_weight,
    input  logic [WEIGHT_W-1:0] edge_weight,
    input  logic [WEIGHT_W-1:0] centre_weight,
    output rgb_t                blurred
);

    logic [2:0][SUM_W-1:0]  diag_sum;
    logic [2:0][SUM_W-1:0]  orth_sum;
    logic [2:0][PROD_W-1:0] diag_prod_next;
    logic [2:0][PROD_W-1:0] orth_prod_next;
    logic [2:0][PROD_W-1:0] mid_prod_next;
    logic [2:0][PROD_W-1:0] diag_prod_reg;
    logic [2:0][PROD_W-1:0] orth_prod_reg;
    logic [2:0][PROD_W-1:0] mid_prod_reg;
    logic [2:0][ACC_W-1:0]  acc;
    logic [2:0][ACC_W-1:0]  scaled;

    // Neighbor sums and weight products, one set per channel
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diag_sum[k] = SUM_W'(diag[0][k]) + SUM_W'(diag[1][k])
                        + SUM_W'(diag[2][k]) + SUM_W'(diag[3][k]);
            orth_sum[k] = SUM_W'(orth[0][k]) + SUM_W'(orth[1][k])
                        + SUM_W'(orth[2][k]) + SUM_W'(orth[3][k]);
            diag_prod_next[k] = PROD_W'(diag_sum[k]) * PROD_W'(corner_weight);
            orth_prod_next[k] = PROD_W'(orth_sum[k]) * PROD_W'(edge_weight);
            mid_prod_next[k]  = PROD_W'(centre[k]) * PROD_W'(centre_weight);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            diag_prod_reg <= diag_prod_next;
            orth_prod_reg <= orth_prod_next;
            mid_prod_reg  <= mid_prod_next;
        end
    end

    // Add, drop the fraction, clip at full scale
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc[k]     = ACC_W'(diag_prod_reg[k]) + ACC_W'(orth_prod_reg[k])
                       + ACC_W'(mid_prod_reg[k]);
            scaled[k]  = acc[k] >> WEIGHT_FRAC_BITS;
            blurred[k] = (|scaled[k][ACC_W-1:CH_W]) ? {CH_W{1'b1}} : scaled[k][CH_W-1:0];
        end
    end

endmodule

// File: rtl/core/gb3_emit.sv
module gb3_emit import gb3_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  grp_t                grp,
    input  logic [2:0]          emit_mask,
    output logic                free,
    gb3_result_if.source        blurred
);

    grp_t             grp_reg;
    logic [2:0]       mask_reg;
    logic [2:0]       mask_next;
    logic [2:0]       sel;
    logic [2:0]       remaining;
    logic             grp_valid;
    logic             out_free;
    logic             out_load;
    logic             grp_done;

    logic             out_valid_reg;
    logic             out_valid_next;
    rgb_t             out_px_reg;
    rgb_t             out_px_next;
    logic [ROW_W-1:0] out_row_reg;
    logic [ROW_W-1:0] out_row_next;
    logic [COL_W-1:0] out_col_reg;
    logic [COL_W-1:0] out_col_next;
    logic             out_last_reg;

    // Pick the earliest pending result of the held group
    always_comb
    begin
        if (mask_reg[0])
        begin
            sel          = 3'b001;
            out_px_next  = grp_reg.first_px;
            out_row_next = grp_reg.row - ROW_W'(1);
            out_col_next = grp_reg.col - COL_W'(1);
        end
        else if (mask_reg[1])
        begin
            sel          = 3'b010;
            out_px_next  = grp_reg.mid_px;
            out_row_next = grp_reg.row - ROW_W'(1);
            out_col_next = grp_reg.col;
        end
        else
        begin
            sel          = 3'b100;
            out_px_next  = grp_reg.cur_px;
            out_row_next = grp_reg.row;
            out_col_next = grp_reg.col;
        end
    end

    assign grp_valid = |mask_reg;
    assign remaining = mask_reg & ~sel;
    assign out_free  = !out_valid_reg || blurred.ready;
    assign out_load  = grp_valid && out_free;
    assign grp_done  = out_load && (remaining == 3'b000);
    assign free      = !grp_valid || grp_done;

    always_comb
    begin
        if (load)
        begin
            mask_next = emit_mask;
        end
        else if (out_load)
        begin
            mask_next = remaining;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (blurred.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= grp;
        end
        if (out_load)
        begin
            out_px_reg   <= out_px_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_last_reg <= (remaining == 3'b000);
        end
    end

    assign blurred.valid       = out_valid_reg;
    assign blurred.out_red     = out_px_reg[CH_RED];
    assign blurred.out_green   = out_px_reg[CH_GREEN];
    assign blurred.out_blue    = out_px_reg[CH_BLUE];
    assign blurred.out_row     = out_row_reg;
    assign blurred.out_col     = out_col_reg;
    assign blurred.last_of_run = out_last_reg;

    // A new group only lands in an empty or draining slot
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result group loaded over a pending group");

    // A word sent out that is not the last keeps the rest of its group
    a_keep_rest: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (remaining != 3'b000)) |=> (mask_reg == $past(remaining)))
        else $error("pending results of a group lost");

    // A stalled word stays on the port unchanged until it is taken
    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        (blurred.valid && !blurred.ready)
            |=> (blurred.valid && $stable(out_px_reg) && $stable(out_row_reg)
                 && $stable(out_col_reg) && $stable(out_last_reg)))
        else $error("result word changed while stalled");

endmodule

// File: rtl/core/gaussian_blur_3x3_rgb_unit.sv
// Streaming 3x3 Gaussian blur of RGB888 pixels.
//
// video carries pixels in raster order, one word per handshake. blurred carries
// the filtered pixels with their row and column; last_of_run marks the final
// word caused by one input pixel. Output lags one row and one column behind the
// input; edge pixels pass through unchanged, and the bottom row is sent as it
// arrives. Interior pixels use corner, edge and centre weights (unsigned,
// 16 fraction bits), truncated and clipped to 255 per channel.
// A word reaches blurred through the input, product, group and result registers
// after the pixel that completes it is taken. Throughput: one pixel per clock while
// blurred is ready; a last-column pixel below the top row sends two words and a
// bottom-row pixel up to three, one word per clock, so the output port sets the
// pace there. Reset clears the row and column counters, the window and all valid
// flags and loads the default size and weights; line buffers are not cleared.
// Registers are written through cfg_write/cfg_index/cfg_data; the user must write
// them only while no pixel is in flight, which the block does not enforce. When
// blurred stalls, the internal stages fill and video.ready drops.
module gaussian_blur_3x3_rgb_unit import gb3_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    gb3_video_if.sink             video,
    gb3_result_if.source          blurred
);

    localparam int CW = $clog2(MAX_WIDTH);

    // Configuration registers
    logic [FW_W-1:0]     frame_width_reg;
    logic [FH_W-1:0]     frame_height_reg;
    logic [WEIGHT_W-1:0] corner_weight_reg;
    logic [WEIGHT_W-1:0] edge_weight_reg;
    logic [WEIGHT_W-1:0] centre_weight_reg;

    // Position counters
    logic [CW-1:0]    col_count_reg;
    logic [CW-1:0]    col_count_next;
    logic [ROW_W-1:0] row_count_reg;
    logic [ROW_W-1:0] row_count_next;
    logic [CW-1:0]    col_last_idx;
    logic [ROW_W-1:0] row_last_idx;
    logic             acc_last_col;
    logic             acc_last_row;
    logic             accept;

    // Input stage
    logic             s1_valid_reg;
    logic             s1_valid_next;
    rgb_t             s1_px_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [CW-1:0]    s1_col_reg;
    logic             s1_last_col_reg;
    logic             s1_last_row_reg;
    logic             s1_move;
    line_pair_t       lines_rd;
    line_pair_t       lines_wr;
    logic [2:0]       s1_mask;
    logic             s1_blur;

    // Window: [0..2] column c-2 top/mid/bottom, [3..5] column c-1
    rgb_t [5:0]       win_reg;
    rgb_t [5:0]       win_next;

    // Product stage
    logic             s2_valid_reg;
    logic             s2_valid_next;
    logic             s2_ready;
    logic             s2_move;
    rgb_t             s2_pass_reg;
    rgb_t             s2_mid_reg;
    rgb_t             s2_px_reg;
    logic [ROW_W-1:0] s2_row_reg;
    logic [CW-1:0]    s2_col_reg;
    logic [2:0]       s2_mask_reg;
    logic             s2_blur_reg;

    rgb_t             blur_px;
    grp_t             grp;
    logic             emit_free;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= FRAME_WIDTH_RST;
            frame_height_reg  <= FRAME_HEIGHT_RST;
            corner_weight_reg <= CORNER_WEIGHT_RST;
            edge_weight_reg   <= EDGE_WEIGHT_RST;
            centre_weight_reg <= CENTRE_WEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[FH_W-1:0];
                REG_CORNER_WEIGHT: corner_weight_reg <= cfg_data[WEIGHT_W-1:0];
                REG_EDGE_WEIGHT:   edge_weight_reg   <= cfg_data[WEIGHT_W-1:0];
                REG_CENTRE_WEIGHT: centre_weight_reg <= cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Last column and row index after clamping the frame size
    always_comb
    begin
        if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            col_last_idx = CW'(MAX_WIDTH - 1);
        end
        else if (frame_width_reg < FW_W'(3))
        begin
            col_last_idx = CW'(2);
        end
        else
        begin
            col_last_idx = CW'(frame_width_reg - FW_W'(1));
        end

        if (frame_height_reg < FH_W'(3))
        begin
            row_last_idx = ROW_W'(2);
        end
        else
        begin
            row_last_idx = frame_height_reg - FH_W'(1);
        end
    end

    // Handshake chain: each stage moves when the next one has room
    assign s2_ready    = !s2_valid_reg || emit_free;
    assign s2_move     = s2_valid_reg && emit_free;
    assign s1_move     = s1_valid_reg && s2_ready;
    assign video.ready = !s1_valid_reg || s2_ready;
    assign accept      = video.valid && video.ready;

    assign acc_last_col = col_count_reg >= col_last_idx;
    assign acc_last_row = row_count_reg >= row_last_idx;

    // Raster position of the next pixel
    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (acc_last_col)
            begin
                col_count_next = '0;
                row_count_next = acc_last_row ? '0 : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + CW'(1);
            end
        end
    end

    assign s1_valid_next = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign s2_valid_next = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_valid_reg);

    // Window slides one column each time a pixel leaves the input stage
    assign win_next = s1_move ? {s1_px_reg, lines_rd.above, lines_rd.two_above, win_reg[5:3]}
                              : win_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            win_reg       <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            win_reg       <= win_next;
        end
    end

    // Input stage payload; the line buffers are read at the same edge
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg[CH_RED]   <= video.in_red;
            s1_px_reg[CH_GREEN] <= video.in_green;
            s1_px_reg[CH_BLUE]  <= video.in_blue;
            s1_row_reg          <= row_count_reg;
            s1_col_reg          <= col_count_reg;
            s1_last_col_reg     <= acc_last_col;
            s1_last_row_reg     <= acc_last_row;
        end
    end

    // Line entry written back: the row above moves up, this pixel becomes the row above
    assign lines_wr.two_above = lines_rd.above;
    assign lines_wr.above     = s1_px_reg;

    gb3_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_count_reg),
        .rd_data (lines_rd),
        .wr_en   (s1_move),
        .wr_addr (s1_col_reg),
        .wr_data (lines_wr)
    );

    // Which results this pixel causes
    assign s1_blur    = (s1_row_reg > ROW_W'(1)) && (s1_col_reg > CW'(1));
    assign s1_mask[0] = (|s1_row_reg) && (|s1_col_reg);
    assign s1_mask[1] = (|s1_row_reg) && s1_last_col_reg;
    assign s1_mask[2] = s1_last_row_reg;

    gb3_kernel u_kernel (
        .clk           (clk),
        .load          (s1_move),
        .diag          ({win_reg[0], win_reg[2], lines_rd.two_above, s1_px_reg}),
        .orth          ({win_reg[1], win_reg[3], win_reg[5], lines_rd.above}),
        .centre        (win_reg[4]),
        .corner_weight (corner_weight_reg),
        .edge_weight   (edge_weight_reg),
        .centre_weight (centre_weight_reg),
        .blurred       (blur_px)
    );

    // Product stage payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_pass_reg <= win_reg[4];
            s2_mid_reg  <= lines_rd.above;
            s2_px_reg   <= s1_px_reg;
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
            s2_mask_reg <= s1_mask;
            s2_blur_reg <= s1_blur;
        end
    end

    assign grp.first_px = s2_blur_reg ? blur_px : s2_pass_reg;
    assign grp.mid_px   = s2_mid_reg;
    assign grp.cur_px   = s2_px_reg;
    assign grp.row      = s2_row_reg;
    assign grp.col      = COL_W'(s2_col_reg);

    gb3_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s2_move),
        .grp       (grp),
        .emit_mask (s2_mask_reg),
        .free      (emit_free),
        .blurred   (blurred)
    );

    // The last pixel of a frame sends the counters back to the origin
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && acc_last_col && acc_last_row)
            |=> ((row_count_reg == '0) && (col_count_reg == '0)))
        else $error("raster counters did not wrap at end of frame");

    // A blurred pixel is always announced as the first result
    a_blur_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_blur_reg) |-> s2_mask_reg[0])
        else $error("blurred pixel without its result flag");

    // No pixel is taken while the input stage is full and blocked
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |-> !video.ready)
        else $error("pixel taken into a blocked input stage");

endmodule

// File: test/gaussian_blur_3x3_rgb_unit_tb.sv
`timescale 1ns / 1ps

module gaussian_blur_3x3_rgb_unit_tb;
    import gb3_pkg::*;

    localparam int CLK_HIGH      = 4;
    localparam int CLK_LOW       = 4;
    localparam int RESET_CYCLES  = 8;
    localparam int IDLE_PCT      = 26;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 380;
    localparam int BIG_FRAME_NO  = 6;
    localparam int STEADY_PIXELS = 100;
    localparam int LIMIT_CYCLES  = 400000;

    // One filtered word as seen on the result port
    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } blur_word_t;

    // Line-buffer blur predictor plus the queue of words still owed by the block
    class blur_scoreboard;
        rgb_t               line_above [MAX_WIDTH_DEF];
        rgb_t               line_two_above [MAX_WIDTH_DEF];
        rgb_t               window [6];
        logic [COL_W-1:0]   col_cnt;
        logic [ROW_W-1:0]   row_cnt;
        logic [FW_W-1:0]    frame_width;
        logic [FH_W-1:0]    frame_height;
        logic [WEIGHT_W-1:0] corner_weight;
        logic [WEIGHT_W-1:0] edge_weight;
        logic [WEIGHT_W-1:0] centre_weight;
        blur_word_t         owed_words[$];
        int unsigned        pixels_taken;
        int unsigned        errors;

        function new();
            foreach (line_above[i]) begin
                line_above[i]     = '0;
                line_two_above[i] = '0;
            end
            foreach (window[i]) window[i] = '0;
            col_cnt       = '0;
            row_cnt       = '0;
            frame_width   = FRAME_WIDTH_RST;
            frame_height  = FRAME_HEIGHT_RST;
            corner_weight = CORNER_WEIGHT_RST;
            edge_weight   = EDGE_WEIGHT_RST;
            centre_weight = CENTRE_WEIGHT_RST;
            pixels_taken  = 0;
            errors        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FRAME_WIDTH:   frame_width   = data[FW_W-1:0];
                REG_FRAME_HEIGHT:  frame_height  = data[FH_W-1:0];
                REG_CORNER_WEIGHT: corner_weight = data[WEIGHT_W-1:0];
                REG_EDGE_WEIGHT:   edge_weight   = data[WEIGHT_W-1:0];
                REG_CENTRE_WEIGHT: centre_weight = data[WEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        // Weighted 3x3 sum on one channel, truncated then clipped to 255
        function logic [CH_W-1:0] blur_channel(rgb_t top, rgb_t mid, rgb_t bot, int ch);
            int unsigned     corners;
            int unsigned     edges;
            int unsigned     centre;
            longint unsigned acc;
            corners = 32'(window[0][ch]) + 32'(window[2][ch]) + 32'(top[ch]) + 32'(bot[ch]);
            edges   = 32'(window[1][ch]) + 32'(window[3][ch]) + 32'(window[5][ch])
                    + 32'(mid[ch]);
            centre  = 32'(window[4][ch]);
            acc = 64'(corners) * 64'(corner_weight) + 64'(edges) * 64'(edge_weight)
                + 64'(centre) * 64'(centre_weight);
            acc = acc >> WEIGHT_FRAC_BITS;
            return (acc > 255) ? 8'd255 : acc[CH_W-1:0];
        endfunction

        function blur_word_t make_word(rgb_t px, int unsigned row, int unsigned col);
            blur_word_t word;
            word.red   = px[CH_RED];
            word.green = px[CH_GREEN];
            word.blue  = px[CH_BLUE];
            word.row   = row[ROW_W-1:0];
            word.col   = col[COL_W-1:0];
            word.last  = 1'b0;
            return word;
        endfunction

        // Advance the predictor by one accepted pixel and queue the words it causes
        function void note_pixel(rgb_t px);
            int unsigned w;
            int unsigned h;
            int unsigned r;
            int unsigned c;
            bit          last_col;
            bit          last_row;
            rgb_t        top;
            rgb_t        mid;
            rgb_t        blur_px;
            blur_word_t  words [3];
            int          n;
            w = 32'(frame_width);
            h = (frame_height < FH_W'(3)) ? 32'd3 : 32'(frame_height);
            if (w < 3) w = 3;
            if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
            r = 32'(row_cnt);
            c = 32'(col_cnt);
            last_col = (c >= w - 1);
            last_row = (r >= h - 1);
            top = line_two_above[c];
            mid = line_above[c];
            n = 0;

            // pixel one row up and one column left: blurred inside, passed on the edge
            if (r >= 1 && c >= 1) begin
                if (r >= 2 && c >= 2) begin
                    for (int ch = 0; ch < 3; ch++)
                        blur_px[ch] = blur_channel(top, mid, px, ch);
                    words[n] = make_word(blur_px, r - 1, c - 1);
                end
                else
                    words[n] = make_word(window[4], r - 1, c - 1);
                n++;
            end
            // right edge pixel of the row above
            if (r >= 1 && last_col) begin
                words[n] = make_word(mid, r - 1, c);
                n++;
            end
            // bottom row goes straight out
            if (last_row) begin
                words[n] = make_word(px, r, c);
                n++;
            end
            for (int i = 0; i < n; i++) begin
                words[i].last = (i == n - 1);
                owed_words.push_back(words[i]);
            end

            window[0] = window[3];
            window[1] = window[4];
            window[2] = window[5];
            window[3] = top;
            window[4] = mid;
            window[5] = px;
            line_two_above[c] = mid;
            line_above[c]     = px;

            if (last_col) begin
                col_cnt = '0;
                row_cnt = last_row ? '0 : row_cnt + ROW_W'(1);
            end
            else
                col_cnt = col_cnt + COL_W'(1);
            pixels_taken++;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(blur_word_t got);
            blur_word_t want;
            if (owed_words.size() == 0) begin
                $error("word with nothing owed: row %0d col %0d", got.row, got.col);
                errors++;
                return;
            end
            want = owed_words.pop_front();
            compare_field("out_red", want.red, got.red);
            compare_field("out_green", want.green, got.green);
            compare_field("out_blue", want.blue, got.blue);
            compare_field("out_row", want.row, got.row);
            compare_field("out_col", want.col, got.col);
            compare_field("last_of_run", want.last, got.last);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    steady;
    int unsigned           cycle_count = 0;
    blur_scoreboard        blur_sb;

    gb3_video_if  pix_in ();
    gb3_result_if pix_out ();

    gaussian_blur_3x3_rgb_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .video     (pix_in),
        .blurred   (pix_out)
    );

    always
    begin
        #CLK_HIGH clk = 1'b1;
        #CLK_LOW  clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: check each accepted word, stall at random
    always @(posedge clk)
    begin : result_side
        blur_word_t got;
        if (rst_n && pix_out.valid && pix_out.ready) begin
            got.red   = pix_out.out_red;
            got.green = pix_out.out_green;
            got.blue  = pix_out.out_blue;
            got.row   = pix_out.out_row;
            got.col   = pix_out.out_col;
            got.last  = pix_out.last_of_run;
            blur_sb.check_word(got);
        end
        pix_out.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic rgb_t random_pixel();
        rgb_t px;
        if ($urandom_range(0, 99) < 15) begin
            for (int ch = 0; ch < 3; ch++)
                px[ch] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        else begin
            for (int ch = 0; ch < 3; ch++)
                px[ch] = CH_W'($urandom_range(0, 255));
        end
        return px;
    endfunction

    // Offer one pixel word, with random gaps before it
    task automatic send_pixel(input rgb_t px);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.in_red   <= px[CH_RED];
        pix_in.in_green <= px[CH_GREEN];
        pix_in.in_blue  <= px[CH_BLUE];
        do
            @(posedge clk);
        while (!pix_in.ready);
        blur_sb.note_pixel(px);
    endtask

    // Hold off input until every owed word is back and the pipe is empty
    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        while (blur_sb.owed_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        blur_sb.write_reg(idx, data);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input logic [CFG_DATA_W-1:0] cw, input logic [CFG_DATA_W-1:0] ew,
                             input logic [CFG_DATA_W-1:0] ctr);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_CORNER_WEIGHT, cw);
        write_reg(REG_EDGE_WEIGHT, ew);
        write_reg(REG_CENTRE_WEIGHT, ctr);
    endtask

    // Random pixels; a full drain before pixel pause_at (negative: none)
    task automatic run_pixels(input int count, input int pause_at);
        for (int i = 0; i < count; i++) begin
            if (i == pause_at)
                wait_drained();
            send_pixel(random_pixel());
        end
    endtask

    task automatic finish_frame();
        do
            send_pixel(random_pixel());
        while (blur_sb.row_cnt != 0 || blur_sb.col_cnt != 0);
    endtask

    initial
    begin
        int                    frame_no;
        int unsigned           random_items;
        int unsigned           start_count;
        int                    w;
        int                    h;
        int                    pause_at;
        logic [WEIGHT_W-1:0]   cw;
        logic [WEIGHT_W-1:0]   ew;
        logic [WEIGHT_W-1:0]   ctr;
        rgb_t                  px;

        blur_sb         = new();
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = REG_FRAME_WIDTH;
        cfg_data        = '0;
        pix_in.valid    = 1'b0;
        pix_in.in_red   = '0;
        pix_in.in_green = '0;
        pix_in.in_blue  = '0;
        steady          = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Undersized registers clamp to 3x3; full weights on a checkerboard saturate
        set_frame(16'd0, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2) ? 24'hFFFFFF : 24'h000000);

        // Centre near unity with tiny edge weight: truncation just below the input
        set_frame(16'd4, 16'd3, 16'd0, 16'd1, 16'hFFFF);
        for (int i = 0; i < 12; i++) begin
            px[CH_RED]   = CH_W'(i * 23);
            px[CH_GREEN] = CH_W'(255 - i * 20);
            px[CH_BLUE]  = (i % 3 == 0) ? 8'hFF : 8'h00;
            send_pixel(px);
        end

        frame_no     = 0;
        random_items = 0;
        while (frame_no <= BIG_FRAME_NO || random_items < RANDOM_ITEMS) begin
            start_count = blur_sb.pixels_taken;
            case (frame_no)
                // width shrunk in the middle of a row: that pixel closes the row
                2: begin
                    set_frame(16'd8, 16'd6, CORNER_WEIGHT_RST, EDGE_WEIGHT_RST,
                              CENTRE_WEIGHT_RST);
                    run_pixels(2 * 8 + 6, -1);
                    wait_drained();
                    write_reg(REG_FRAME_WIDTH, 16'd4);
                    finish_frame();
                end
                // tallest frame, cut short by lowering the height at a row start
                4: begin
                    set_frame(16'd3, 16'd65535, 16'd3000, 16'd9000, 16'd20000);
                    run_pixels(3 * 4, -1);
                    wait_drained();
                    write_reg(REG_FRAME_HEIGHT, 16'd3);
                    finish_frame();
                end
                // oversized width clamps to the widest row, so the first row runs on
                // until the width is lowered; no idling at all
                BIG_FRAME_NO: begin
                    set_frame(16'd4095, 16'd3, 16'd1000, 16'd2000, 16'd30000);
                    steady = 1'b1;
                    run_pixels(STEADY_PIXELS, -1);
                    wait_drained();
                    write_reg(REG_FRAME_WIDTH, 16'd4);
                    finish_frame();
                    wait_drained();
                    steady = 1'b0;
                end
                default: begin
                    w = ($urandom_range(0, 99) < 80) ? $urandom_range(3, 12)
                                                     : $urandom_range(13, 40);
                    h = $urandom_range(3, 6);
                    case ($urandom_range(0, 3))
                        0: begin
                            cw  = CORNER_WEIGHT_RST;
                            ew  = EDGE_WEIGHT_RST;
                            ctr = CENTRE_WEIGHT_RST;
                        end
                        1: begin
                            cw  = WEIGHT_W'($urandom_range(0, 12000));
                            ew  = WEIGHT_W'($urandom_range(0, 12000));
                            ctr = WEIGHT_W'($urandom_range(0, 20000));
                        end
                        2: begin
                            cw  = WEIGHT_W'($urandom_range(0, 65535));
                            ew  = WEIGHT_W'($urandom_range(0, 65535));
                            ctr = WEIGHT_W'($urandom_range(0, 65535));
                        end
                        default: begin
                            cw  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                            ew  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                            ctr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                        end
                    endcase
                    pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w * h - 1) : -1;
                    set_frame(CFG_DATA_W'(w), CFG_DATA_W'(h), cw, ew, ctr);
                    run_pixels(w * h, pause_at);
                end
            endcase
            random_items += blur_sb.pixels_taken - start_count;
            frame_no++;
        end

        // Let the tail drain and watch for stray words
        wait_drained();
        repeat (4 * DRAIN_CYCLES) @(posedge clk);
        if (blur_sb.errors == 0 && blur_sb.owed_words.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/gb3_pkg.sv
rtl/core/gb3_if.sv
rtl/core/gb3_line_buf.sv
rtl/core/gb3_kernel.sv
rtl/core/gb3_emit.sv
rtl/core/gaussian_blur_3x3_rgb_unit.sv
test/gaussian_blur_3x3_rgb_unit_tb.sv
